/* rtl/core/bfba_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the microcode ROM of the best-fit block allocator.
// No dependencies; every other file of the block imports this package.
package bfba_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int IDX_W      = 4;
    localparam int SIZE_W     = 16;
    localparam int TOT_W      = 32;
    localparam int NUM_W      = 5;
    localparam int CMD_W      = 2;
    localparam int STEP_W     = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_REQUEST = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    // datapath operation selected by one control word
    typedef enum logic [2:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_SCAN,
        OP_EMIT,
        OP_LOAD,
        OP_CLEAR
    } t_op;

    // jump condition of one control word
    typedef enum logic [1:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_DISPATCH,
        JC_SCAN_MORE
    } t_jc;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_FETCH = 3'd0;
    localparam t_step STEP_SCAN  = 3'd1;
    localparam t_step STEP_EMIT  = 3'd2;
    localparam t_step STEP_LOAD  = 3'd3;
    localparam t_step STEP_CLEAR = 3'd4;

    typedef struct packed {
        logic  in_ready;
        logic  wait_out;
        t_op   op;
        t_jc   jc;
        t_step target;
    } t_cw;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic scan_more;
        logic out_free;
    } t_dp_stat;

    function automatic t_cw ucode_rom(input t_step step);
        t_cw cw;
        cw = '{in_ready: 1'b0, wait_out: 1'b0, op: OP_NOP, jc: JC_ALWAYS,
               target: STEP_FETCH};
        unique case (step)
            STEP_FETCH: begin
                cw.in_ready = 1'b1;
                cw.op       = OP_CAPTURE;
                cw.jc       = JC_DISPATCH;
            end
            STEP_SCAN: begin
                cw.op     = OP_SCAN;
                cw.jc     = JC_SCAN_MORE;
                cw.target = STEP_SCAN;
            end
            STEP_EMIT: begin
                cw.wait_out = 1'b1;
                cw.op       = OP_EMIT;
                cw.target   = STEP_FETCH;
            end
            STEP_LOAD: begin
                cw.op     = OP_LOAD;
                cw.target = STEP_EMIT;
            end
            STEP_CLEAR: begin
                cw.op     = OP_CLEAR;
                cw.target = STEP_EMIT;
            end
            default: begin
                cw.target = STEP_FETCH;
            end
        endcase
        return cw;
    endfunction

    // entry step for each command code
    function automatic t_step dispatch(input logic [CMD_W-1:0] cmd);
        t_step s;
        unique case (cmd)
            CMD_LOAD:    s = STEP_LOAD;
            CMD_REQUEST: s = STEP_SCAN;
            CMD_CLEAR:   s = STEP_CLEAR;
            default:     s = STEP_EMIT;
        endcase
        return s;
    endfunction

endpackage

/* rtl/core/bfba_req_if.sv */
`timescale 1ns / 1ps
// Request channel of the best-fit block allocator: valid/ready plus command payload.
// Depends on bfba_pkg for field widths.
interface bfba_req_if;
    import bfba_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  block_index;
    logic [SIZE_W-1:0] size;

    modport source (output valid, cmd, block_index, size, input ready);
    modport sink   (input valid, cmd, block_index, size, output ready);
endinterface

/* rtl/core/bfba_rsp_if.sv */
`timescale 1ns / 1ps
// Result channel of the best-fit block allocator: valid/ready plus grant payload.
// Depends on bfba_pkg for field widths.
interface bfba_rsp_if;
    import bfba_pkg::*;

    logic              valid;
    logic              ready;
    logic              granted;
    logic [IDX_W-1:0]  chosen_block;
    logic [SIZE_W-1:0] chosen_size;
    logic [SIZE_W-1:0] fragment;
    logic [TOT_W-1:0]  total_fragment;

    modport source (output valid, granted, chosen_block, chosen_size, fragment,
                    total_fragment, input ready);
    modport sink   (input valid, granted, chosen_block, chosen_size, fragment,
                    total_fragment, output ready);
endinterface

/* rtl/core/best_fit_block_allocator_core.sv */
`timescale 1ns / 1ps
// Best-fit block allocator top level: 16-entry block size table, allocated flags and
// a saturating fragment total. Depends on bfba_pkg, both interfaces, bfba_useq, bfba_dpath.
//
// Usage:
//   i_req carries one request: cmd (load, allocate, clear), block_index and size.
//   o_rsp returns exactly one result per request: granted, chosen_block,
//   chosen_size, fragment and the running total_fragment.
//   i_cfg_we/i_cfg_wdata write num_blocks (blocks searched); write it only while
//   the block is idle.
// Timing:
//   One request at a time. An allocate request runs fetch, one scan step per entry
//   of the first min(num_blocks, 16) (at least one step), each entry read from the
//   size memory and compared with the best so far, then emit; its result is
//   registered at emit. Load and clear run fetch, their own step and emit; an unused
//   command runs fetch and emit.
// Reset: synchronous, active low. Clear all sizes (through per-entry valid bits),
//   flags, the total and num_blocks; requests are taken right after release.
// Stall: the result waits in an output register; a new request is accepted
//   meanwhile and is processed up to its own result, which holds until the slot frees.
module best_fit_block_allocator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bfba_req_if.sink                     i_req,
    bfba_rsp_if.source                   o_rsp,
    input  logic                         i_cfg_we,
    input  logic [bfba_pkg::NUM_W-1:0]   i_cfg_wdata
);
    import bfba_pkg::*;

    t_cw      cw;
    t_dp_stat stat;
    logic     in_accept;

    // take a request only in the fetch step, and never while in reset
    assign i_req.ready = cw.in_ready && i_rst_n;
    assign in_accept   = i_req.valid && i_req.ready;

    bfba_useq u_useq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_in_cmd    (i_req.cmd),
        .i_stat      (stat),
        .o_cw        (cw)
    );

    bfba_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cw             (cw),
        .i_in_accept      (in_accept),
        .i_in_index       (i_req.block_index),
        .i_in_size        (i_req.size),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_out_ready      (o_rsp.ready),
        .o_stat           (stat),
        .o_out_valid      (o_rsp.valid),
        .o_granted        (o_rsp.granted),
        .o_chosen_block   (o_rsp.chosen_block),
        .o_chosen_size    (o_rsp.chosen_size),
        .o_fragment       (o_rsp.fragment),
        .o_total_fragment (o_rsp.total_fragment)
    );

endmodule

/* rtl/core/bfba_useq.sv */
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control word ROM lookup and jump logic.
// Depends on bfba_pkg (control word type, ROM and dispatch functions).
module bfba_useq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_accept,
    input  logic [bfba_pkg::CMD_W-1:0]   i_in_cmd,
    input  bfba_pkg::t_dp_stat           i_stat,
    output bfba_pkg::t_cw                o_cw
);
    import bfba_pkg::*;

    t_step r_step;
    t_step n_step;
    t_cw   cw;

    assign cw   = ucode_rom(r_step);
    assign o_cw = cw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        n_step = r_step;
        if (!(cw.wait_out && !i_stat.out_free)) begin
            unique case (cw.jc)
                JC_NEXT:      n_step = r_step + t_step'(1);
                JC_ALWAYS:    n_step = cw.target;
                JC_DISPATCH:  n_step = i_in_accept ? dispatch(i_in_cmd) : r_step;
                JC_SCAN_MORE: n_step = i_stat.scan_more ? cw.target
                                                        : r_step + t_step'(1);
                default:      n_step = STEP_FETCH;
            endcase
        end
    end

endmodule

/* rtl/core/bfba_dpath.sv */
`timescale 1ns / 1ps
// Datapath: block size memory, allocated flags, scan/compare registers, fragment
// total and the output register. Driven by control words; depends on bfba_pkg.
module bfba_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bfba_pkg::t_cw                i_cw,
    input  logic                         i_in_accept,
    input  logic [bfba_pkg::IDX_W-1:0]   i_in_index,
    input  logic [bfba_pkg::SIZE_W-1:0]  i_in_size,
    input  logic                         i_cfg_we,
    input  logic [bfba_pkg::NUM_W-1:0]   i_cfg_wdata,
    input  logic                         i_out_ready,
    output bfba_pkg::t_dp_stat           o_stat,
    output logic                         o_out_valid,
    output logic                         o_granted,
    output logic [bfba_pkg::IDX_W-1:0]   o_chosen_block,
    output logic [bfba_pkg::SIZE_W-1:0]  o_chosen_size,
    output logic [bfba_pkg::SIZE_W-1:0]  o_fragment,
    output logic [bfba_pkg::TOT_W-1:0]   o_total_fragment
);
    import bfba_pkg::*;

    logic [SIZE_W-1:0]     mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_vld;
    logic [MAX_BLOCKS-1:0] r_flags;
    logic [NUM_W-1:0]      r_num_blocks;
    logic [TOT_W-1:0]      r_sum;

    logic [IDX_W-1:0]      r_idx;
    logic [SIZE_W-1:0]     r_size;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_found;
    logic [IDX_W-1:0]      r_best_idx;
    logic [SIZE_W-1:0]     r_best_size;
    logic [SIZE_W-1:0]     r_rd_data;
    logic                  r_rd_vld;

    logic                  r_out_valid;
    logic                  r_granted;
    logic [IDX_W-1:0]      r_chosen_block;
    logic [SIZE_W-1:0]     r_chosen_size;
    logic [SIZE_W-1:0]     r_fragment;
    logic [TOT_W-1:0]      r_total;

    logic [NUM_W-1:0]      limit;
    logic [IDX_W-1:0]      rd_addr;
    logic [SIZE_W-1:0]     rd_val;
    logic                  in_range;
    logic                  take;
    logic                  out_free;
    logic                  emit;
    logic                  capture;
    logic [SIZE_W-1:0]     frag;
    logic [TOT_W:0]        sum_ext;
    logic [TOT_W-1:0]      sum_new;

    assign limit    = (r_num_blocks > NUM_W'(MAX_BLOCKS)) ? NUM_W'(MAX_BLOCKS)
                                                          : r_num_blocks;
    assign rd_addr  = (i_cw.op == OP_CAPTURE) ? '0 : r_cmp_idx + IDX_W'(1);
    assign rd_val   = r_rd_vld ? r_rd_data : '0;
    assign in_range = {1'b0, r_cmp_idx} < limit;
    assign take     = in_range && !r_flags[r_cmp_idx] && (rd_val >= r_size)
                      && (!r_found || (rd_val < r_best_size));
    assign out_free = !r_out_valid || i_out_ready;
    assign emit     = (i_cw.op == OP_EMIT) && out_free;
    assign capture  = (i_cw.op == OP_CAPTURE) && i_in_accept;
    assign frag     = r_found ? (r_best_size - r_size) : '0;
    assign sum_ext  = {1'b0, r_sum} + {{(TOT_W + 1 - SIZE_W){1'b0}}, frag};
    assign sum_new  = sum_ext[TOT_W] ? '1 : sum_ext[TOT_W-1:0];

    assign o_stat.scan_more = ({1'b0, r_cmp_idx} + NUM_W'(1)) < limit;
    assign o_stat.out_free  = out_free;

    // size memory: written on load, read one entry ahead of the compare
    always_ff @(posedge i_clk) begin
        if ((i_cw.op == OP_LOAD) && (32'(r_idx) < MAX_BLOCKS)) begin
            mem[r_idx] <= r_size;
        end
        r_rd_data <= mem[rd_addr];
        r_rd_vld  <= r_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_flags      <= '0;
            r_num_blocks <= '0;
            r_sum        <= '0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_blocks <= i_cfg_wdata;
            end
            if (capture) begin
                r_found <= 1'b0;
            end
            if ((i_cw.op == OP_SCAN) && take) begin
                r_found <= 1'b1;
            end
            if ((i_cw.op == OP_LOAD) && (32'(r_idx) < MAX_BLOCKS)) begin
                r_vld[r_idx]   <= 1'b1;
                r_flags[r_idx] <= 1'b0;
            end
            if (i_cw.op == OP_CLEAR) begin
                r_flags <= '0;
                r_sum   <= '0;
            end
            if (emit && r_found) begin
                r_flags[r_best_idx] <= 1'b1;
                r_sum               <= sum_new;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_idx       <= i_in_index;
            r_size      <= i_in_size;
            r_cmp_idx   <= '0;
            r_best_idx  <= '0;
            r_best_size <= '0;
        end
        if (i_cw.op == OP_SCAN) begin
            r_cmp_idx <= r_cmp_idx + IDX_W'(1);
            if (take) begin
                r_best_idx  <= r_cmp_idx;
                r_best_size <= rd_val;
            end
        end
        if (emit) begin
            r_granted      <= r_found;
            r_chosen_block <= r_best_idx;
            r_chosen_size  <= r_best_size;
            r_fragment     <= frag;
            r_total        <= r_found ? sum_new : r_sum;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_granted        = r_granted;
    assign o_chosen_block   = r_chosen_block;
    assign o_chosen_size    = r_chosen_size;
    assign o_fragment       = r_fragment;
    assign o_total_fragment = r_total;

endmodule

/* rtl/core/bfba_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for the best-fit block allocator, bound to the top level.
// Depends on bfba_pkg for field widths.
module bfba_chk (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rsp_valid,
    input  logic                         i_rsp_ready,
    input  logic                         i_granted,
    input  logic [bfba_pkg::IDX_W-1:0]   i_chosen_block,
    input  logic [bfba_pkg::SIZE_W-1:0]  i_chosen_size,
    input  logic [bfba_pkg::SIZE_W-1:0]  i_fragment
);
    import bfba_pkg::*;

    // hold a stalled result
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped while stalled");

    // drop all results right after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_rsp_valid)
        else $error("result right after reset");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_granted |->
            (i_chosen_block == '0) && (i_chosen_size == '0) && (i_fragment == '0))
        else $error("refused result carries nonzero fields");

    a_frag_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_granted |-> i_fragment <= i_chosen_size)
        else $error("fragment larger than chosen block");

endmodule

bind best_fit_block_allocator_core bfba_chk u_bfba_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_granted      (o_rsp.granted),
    .i_chosen_block (o_rsp.chosen_block),
    .i_chosen_size  (o_rsp.chosen_size),
    .i_fragment     (o_rsp.fragment)
);
